[rtl/dfb_pkg.sv]
package dfb_pkg;

  localparam int HDR_LEN   = 8;
  localparam int HDR_IDX_W = $clog2(HDR_LEN);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 40;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_XOR_OUT = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CALL_SIGN   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    PH_START,
    PH_HDR,
    PH_DATA,
    PH_CRC0,
    PH_CRC1
  } phase_e;

endpackage

[rtl/data_frame_builder_crc16.sv]
// Downlink frame builder with reflected CRC-16 (poly 0x8408, init 0xFFFF,
// inverted at the end, low byte sent first).
// Input channel (in_valid_i/in_ready_o): one item per transfer. The first
// item of a packet produces an 8-byte header (flag, five call-sign bytes,
// zero, packet id), then its payload byte if the declared length is nonzero;
// later items one byte each; the closing item also gives the two CRC bytes.
// Output channel (out_valid_o/out_ready_i): one frame byte per transfer,
// frame_last_o and fill_after_o on the final byte, oversize_o on header-only
// frames whose declared length exceeded PAYLOAD_MAX.
// An accepted item is captured in the hold register at the transfer edge;
// its first byte is then registered in the output register.
// Throughput: one output byte per cycle from the byte sequencer while the
// receiver takes bytes; a mid-packet payload item gives one byte, a closing
// item three, a first item 8 to 11, and a swallowed surplus item none.
// The next item is taken in the cycle the current one emits its final byte
// or is swallowed. Reset clears the hold and output valid flags, the packet
// state and the configuration registers; no clearing pass is needed.
// When the receiver stalls the output register holds its byte and the
// sequencer and input side wait behind it.
module data_frame_builder_crc16 #(
  parameter int PAYLOAD_MAX = 90,
  parameter int FRAME_LEN   = 100
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dfb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dfb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      packet_id_i,
  input  logic [7:0]                      payload_len_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            frame_last_o,
  output logic [6:0]                      fill_after_o,
  output logic                            oversize_o
);
  import dfb_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
  localparam int FILL_OVER_I = (FRAME_LEN - HDR_LEN > 127) ? 127 : FRAME_LEN - HDR_LEN;
  localparam logic [6:0] FILL_OVER = 7'(FILL_OVER_I);
  localparam logic [8:0] FRAME_LEN_9 = 9'(FRAME_LEN);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_LEN - 1);

  // configuration
  logic [7:0]  header_byte_q;
  logic [39:0] call_sign_q;

  // hold register
  logic       hold_valid_q;
  logic [7:0] pid_q, len_q, db_q;
  logic       last_q;

  // packet state
  phase_e               ph_q, ph_d;
  logic [HDR_IDX_W-1:0] hdr_idx_q, hdr_idx_d;
  logic                 in_packet_q, in_packet_d;
  logic                 drop_q, drop_d;
  logic                 over_q, over_d;
  logic [15:0]          crc_q, crc_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [7:0]           decl_q, decl_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [6:0] out_fill_q, out_fill_d;
  logic       out_over_q, out_over_d;

  logic             emit, final_step, step, out_free;
  logic [15:0]      crc_base, crc_next;
  logic [7:0]       crc_byte, hdr_byte;
  logic [CNT_W-1:0] cnt_inc;
  logic [8:0]       used;
  logic [8:0]       fill_diff;
  logic [6:0]       fill_crc;
  logic             len_over;

  dfb_crc16_byte u_crc (
    .crc_i  (crc_base),
    .byte_i (crc_byte),
    .crc_o  (crc_next)
  );

  always_comb begin
    case (hdr_idx_q)
      HDR_IDX_W'(0): hdr_byte = header_byte_q;
      HDR_IDX_W'(6): hdr_byte = 8'h00;
      HDR_IDX_W'(7): hdr_byte = pid_q;
      default:       hdr_byte = call_sign_q[8*(int'(hdr_idx_q)-1) +: 8];
    endcase
  end

  assign len_over = 9'(len_q) > 9'(PAYLOAD_MAX);
  assign cnt_inc  = count_q + CNT_W'(1);

  // fill after the crc: frame length minus emitted bytes, clamped to 0..127
  assign used      = 9'(HDR_LEN + 2) + 9'(count_q);
  assign fill_diff = FRAME_LEN_9 - used;
  always_comb begin
    if (used >= FRAME_LEN_9) begin
      fill_crc = 7'd0;
    end else if (fill_diff > 9'd127) begin
      fill_crc = 7'd127;
    end else begin
      fill_crc = fill_diff[6:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ph_d        = ph_q;
    hdr_idx_d   = hdr_idx_q;
    in_packet_d = in_packet_q;
    drop_d      = drop_q;
    over_d      = over_q;
    crc_d       = crc_q;
    count_d     = count_q;
    decl_d      = decl_q;
    crc_base    = crc_q;
    crc_byte    = db_q;
    emit        = 1'b0;
    final_step  = 1'b0;
    out_byte_d  = db_q;
    out_last_d  = 1'b0;
    out_fill_d  = 7'd0;
    out_over_d  = 1'b0;

    case (ph_q)
      PH_START: begin
        if (drop_q) begin
          // surplus item after an early close: swallowed
          final_step = 1'b1;
          if (last_q) begin
            drop_d = 1'b0;
          end
        end else if (!in_packet_q) begin
          emit       = 1'b1;
          out_byte_d = hdr_byte;
          out_over_d = len_over;
          crc_base   = CRC_INIT;
          crc_byte   = hdr_byte;
          crc_d      = crc_next;
          count_d    = '0;
          decl_d     = len_q;
          over_d     = len_over;
          hdr_idx_d  = HDR_IDX_W'(1);
          ph_d       = PH_HDR;
        end else begin
          emit    = 1'b1;
          crc_d   = crc_next;
          count_d = cnt_inc;
          if (9'(cnt_inc) >= 9'(decl_q) || last_q) begin
            ph_d = PH_CRC0;
          end else begin
            final_step = 1'b1;
          end
        end
      end
      PH_HDR: begin
        emit       = 1'b1;
        out_byte_d = hdr_byte;
        out_over_d = over_q;
        crc_byte   = hdr_byte;
        crc_d      = crc_next;
        hdr_idx_d  = hdr_idx_q + HDR_IDX_W'(1);
        if (hdr_idx_q == HDR_LAST) begin
          if (over_q) begin
            out_last_d = 1'b1;
            out_fill_d = FILL_OVER;
            drop_d     = !last_q;
            final_step = 1'b1;
          end else begin
            in_packet_d = 1'b1;
            ph_d        = (decl_q == 8'd0) ? PH_CRC0 : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        emit    = 1'b1;
        crc_d   = crc_next;
        count_d = cnt_inc;
        if (9'(cnt_inc) >= 9'(decl_q) || last_q) begin
          ph_d = PH_CRC0;
        end else begin
          final_step = 1'b1;
        end
      end
      PH_CRC0: begin
        emit       = 1'b1;
        out_byte_d = crc_q[7:0] ^ CRC_XOR_OUT[7:0];
        ph_d       = PH_CRC1;
      end
      PH_CRC1: begin
        emit        = 1'b1;
        out_byte_d  = crc_q[15:8] ^ CRC_XOR_OUT[15:8];
        out_last_d  = 1'b1;
        out_fill_d  = fill_crc;
        in_packet_d = 1'b0;
        drop_d      = !last_q;
        final_step  = 1'b1;
      end
      default: begin
        final_step = 1'b1;
      end
    endcase

    if (final_step) begin
      ph_d = PH_START;
    end
  end

  assign step       = hold_valid_q && (out_free || !emit);
  assign in_ready_o = !hold_valid_q || (step && final_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= '0;
      call_sign_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEADER_BYTE: header_byte_q <= cfg_wdata_i[7:0];
        REG_CALL_SIGN:   call_sign_q   <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pid_q  <= packet_id_i;
      len_q  <= payload_len_i;
      db_q   <= data_byte_i;
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_START;
      hdr_idx_q   <= '0;
      in_packet_q <= 1'b0;
      drop_q      <= 1'b0;
      over_q      <= 1'b0;
      crc_q       <= CRC_INIT;
      count_q     <= '0;
      decl_q      <= '0;
    end else if (step) begin
      ph_q        <= ph_d;
      hdr_idx_q   <= hdr_idx_d;
      in_packet_q <= in_packet_d;
      drop_q      <= drop_d;
      over_q      <= over_d;
      crc_q       <= crc_d;
      count_q     <= count_d;
      decl_q      <= decl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      out_fill_q <= out_fill_d;
      out_over_q <= out_over_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign frame_last_o = out_last_q;
  assign fill_after_o = out_fill_q;
  assign oversize_o   = out_over_q;

  a_no_drop_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_packet_q && drop_q))
    else $error("drop and in-packet both set");

  a_fill_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_last_o |-> fill_after_o == 7'd0)
    else $error("fill reported on a non-final byte");

  a_ready_means_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && hold_valid_q |-> step && final_step)
    else $error("item released before its final byte");

  a_hdr_idx_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_HDR |-> hdr_idx_q != '0)
    else $error("header index wrapped");

  a_emit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit |=> out_valid_o)
    else $error("emitted byte lost");

endmodule

[rtl/dfb_crc16_byte.sv]
module dfb_crc16_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import dfb_pkg::*;

  logic [15:0] c;
  logic [7:0]  b;

  // reflected crc, one bit per step, lsb first
  always_comb begin
    c = crc_i;
    b = byte_i;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    crc_o = c;
  end

endmodule
